/* hdl/ppusar_pkg.sv */
// shared types, command codes and address masks for the scroll address register unit
package ppusar_pkg;

    // command codes
    localparam logic [3:0] CMD_CTRL_WR   = 4'd0;
    localparam logic [3:0] CMD_MASK_WR   = 4'd1;
    localparam logic [3:0] CMD_SCROLL_WR = 4'd2;
    localparam logic [3:0] CMD_ADDR_WR   = 4'd3;
    localparam logic [3:0] CMD_DATA_STEP = 4'd4;
    localparam logic [3:0] CMD_STATUS_RD = 4'd5;
    localparam logic [3:0] CMD_COARSE_X  = 4'd6;
    localparam logic [3:0] CMD_LINE_END  = 4'd7;
    localparam logic [3:0] CMD_PRERENDER = 4'd8;

    // address masks and steps
    localparam logic [15:0] COARSE_X_WRAP  = 16'h041F;
    localparam logic [15:0] HORIZ_BITS     = 16'h041F;
    localparam logic [15:0] LINE_KEEP      = 16'h7BE0;
    localparam logic [15:0] LOW_TWELVE     = 16'h0FFF;
    localparam logic [15:0] ROW_WRAP_FLIP  = 16'h0BA0;
    localparam logic [15:0] ROW_CLEAR_FLIP = 16'h03E0;
    localparam logic [15:0] FINE_Y_ONE     = 16'h1000;
    localparam logic [15:0] COARSE_Y_ONE   = 16'h0020;
    localparam logic [15:0] ROW_STEP       = 16'h0020;
    localparam logic [4:0]  ROW_LAST       = 5'd29;
    localparam logic [4:0]  ROW_MAX        = 5'd31;
    localparam logic [2:0]  FINE_Y_MAX     = 3'd7;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] value;
    } ppusar_item_t;

    typedef struct packed {
        logic [15:0] vram_address;
        logic [14:0] latch_address;
        logic [2:0]  fine_x;
        logic        second_write;
        logic        step_by_row;
        logic        background_on;
        logic        sprites_on;
    } ppusar_regs_t;

endpackage

/* hdl/ppusar_in_stage.sv */
// input register stage holding one accepted command
module ppusar_in_stage
    import ppusar_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  advance,
    output logic                  item_valid,
    output ppusar_item_t          item
);

    logic         valid_reg;
    logic         valid_next;
    ppusar_item_t item_reg;

    // room when empty or when the held command leaves this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.cmd   <= s_tdata[3:0];
            item_reg.value <= s_tdata[11:4];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/ppusar_update.sv */
// next register state for one command
module ppusar_update
    import ppusar_pkg::*;
(
    input  ppusar_item_t item,
    input  ppusar_regs_t regs,
    output ppusar_regs_t regs_next
);

    function automatic logic [15:0] coarse_step(input logic [15:0] a);
        if (a[4:0] == 5'h1F) begin
            return a ^ COARSE_X_WRAP;
        end
        return a + 16'd1;
    endfunction

    logic [15:0] x_once;
    logic [15:0] x_twice;
    logic [15:0] y_stepped;
    logic [15:0] y_base;
    logic [15:0] line_addr;
    logic [15:0] latch_wide;
    logic        render_on;

    assign latch_wide = {1'b0, regs.latch_address};
    assign render_on  = regs.background_on || regs.sprites_on;
    assign x_once     = coarse_step(regs.vram_address);
    assign x_twice    = coarse_step(x_once);
    assign y_base     = x_twice & LOW_TWELVE;

    // fine y, then coarse y with the attribute-row wrap
    always_comb begin
        if (x_twice[14:12] == FINE_Y_MAX) begin
            if (x_twice[9:5] == ROW_LAST) begin
                y_stepped = y_base ^ ROW_WRAP_FLIP;
            end else if (x_twice[9:5] == ROW_MAX) begin
                y_stepped = y_base ^ ROW_CLEAR_FLIP;
            end else begin
                y_stepped = y_base + ROW_STEP;
            end
        end else begin
            y_stepped = x_twice + FINE_Y_ONE;
        end
    end

    assign line_addr = render_on ? ((y_stepped & LINE_KEEP) | (latch_wide & HORIZ_BITS))
                                 : x_twice;

    always_comb begin
        regs_next = regs;
        unique case (item.cmd)
            CMD_CTRL_WR: begin
                regs_next.latch_address[11:10] = item.value[1:0];
                regs_next.step_by_row          = item.value[2];
            end
            CMD_MASK_WR: begin
                regs_next.background_on = item.value[3];
                regs_next.sprites_on    = item.value[4];
            end
            CMD_SCROLL_WR: begin
                if (!regs.second_write) begin
                    regs_next.latch_address[4:0] = item.value[7:3];
                    regs_next.fine_x             = item.value[2:0];
                end else begin
                    regs_next.latch_address[9:5]   = item.value[7:3];
                    regs_next.latch_address[14:12] = item.value[2:0];
                end
                regs_next.second_write = !regs.second_write;
            end
            CMD_ADDR_WR: begin
                if (!regs.second_write) begin
                    regs_next.latch_address[13:8] = item.value[5:0];
                    regs_next.latch_address[14]   = 1'b0;
                end else begin
                    regs_next.latch_address[7:0] = item.value;
                    regs_next.vram_address = {1'b0, regs.latch_address[14:8], item.value};
                end
                regs_next.second_write = !regs.second_write;
            end
            CMD_DATA_STEP: begin
                regs_next.vram_address = regs.vram_address
                                       + (regs.step_by_row ? COARSE_Y_ONE : 16'd1);
            end
            CMD_STATUS_RD: begin
                regs_next.second_write = 1'b0;
            end
            CMD_COARSE_X: begin
                regs_next.vram_address = x_once;
            end
            CMD_LINE_END: begin
                regs_next.vram_address = line_addr;
            end
            CMD_PRERENDER: begin
                if (render_on) begin
                    regs_next.vram_address = latch_wide;
                end
            end
            default: begin
                regs_next = regs;
            end
        endcase
    end

endmodule

/* hdl/ppu_scroll_address_registers_unit.sv */
// top level of the scroll and video address register unit
//
// one command enters on the s_ channel, one result leaves on the m_ channel
// per command, in order. s_tdata carries the command code and the written
// byte; m_tdata carries the address, latch, fine x and write toggle as they
// stand after the command.
//
// a command is captured in an input register, then the register update is
// worked out in one pass of logic and lands in the state and the output
// register together. m_tvalid rises once the command has passed through
// the input register and then the output register.
// throughput is one command per cycle while m_tready holds: the input stage
// takes a new transfer while the output register is full as long as that
// result is taken in the same cycle.
//
// when the receiver stalls, the result holds on m_tdata, the input register
// fills, and s_tready drops until m_tready returns.
//
// a synchronous low aresetn empties both stages and clears the register state:
// address, latch, fine x, toggle, step size and render enables.
module ppu_scroll_address_registers_unit
    import ppusar_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // cmd[3:0], value[11:4], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // vram_address[15:0], latch_address[30:16],
                                              // fine_x[33:31], second_write[34], zero pad
);

    logic          item_valid;
    ppusar_item_t  item;
    logic          advance;
    logic          fire;

    ppusar_regs_t  regs_reg;
    ppusar_regs_t  regs_next;
    ppusar_regs_t  upd;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // output register frees when empty or when its result is taken
    assign advance = !out_valid_reg || m_tready;
    // command moves from input register into state and result
    assign fire    = item_valid && advance;

    ppusar_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ppusar_update u_update (
        .item      (item),
        .regs      (regs_reg),
        .regs_next (upd)
    );

    // state only moves with a result, so the held result always mirrors it
    assign regs_next      = fire ? upd : regs_reg;
    assign out_valid_next = advance ? item_valid : out_valid_reg;
    assign out_data_next  = {5'd0, upd.second_write, upd.fine_x,
                             upd.latch_address, upd.vram_address};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            regs_reg      <= regs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a waiting result always matches the live register state
    a_result_mirrors_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == regs_reg.vram_address
                      && m_tdata[30:16] == regs_reg.latch_address
                      && m_tdata[33:31] == regs_reg.fine_x
                      && m_tdata[34] == regs_reg.second_write))
        else $error("result does not match register state");

    // full input stage behind a stalled result blocks new transfers
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // state holds while no command is applied
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(regs_reg))
        else $error("register state changed without a command");

endmodule
